// ===== hw/rtl/segment_gyration_histogram_assert.svh =====
// Assertion macros for the block's top-level RTL file, the one file that includes them.
`ifndef SEGMENT_GYRATION_HISTOGRAM_ASSERT_SVH
`define SEGMENT_GYRATION_HISTOGRAM_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SGH_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SGH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/sgh_pkg.sv =====
package sgh_pkg;

	localparam int BEADS_PER_FRAME = 400;
	localparam int SEG_LEN = 10;
	localparam int HIST_BINS = 1024;
	localparam int NSEG = BEADS_PER_FRAME / SEG_LEN;

	localparam int POS_W = $clog2(BEADS_PER_FRAME);
	localparam int SLOT_W = $clog2(SEG_LEN);
	localparam int CNT_W = $clog2(SEG_LEN + 1);
	localparam int SEGC_W = $clog2(NSEG + 1);
	localparam int SEG_W = $clog2(NSEG);
	localparam int BIN_W = $clog2(HIST_BINS);
	localparam int SUM_W = 33 + SLOT_W;
	localparam int ACC_W = 66 + $clog2(3 * SEG_LEN);
	localparam int SQ_W = 2 * ((ACC_W + 1) / 2);
	localparam int ROOT_W = SQ_W / 2;
	localparam int REM_W = $clog2(SEG_LEN);
	localparam int DIV_DIGIT_W = 8;
	localparam int DIV_W = DIV_DIGIT_W * ((ACC_W + DIV_DIGIT_W - 1) / DIV_DIGIT_W);
	localparam int DIV_STEPS = DIV_W / DIV_DIGIT_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);
	localparam int DIV_RECIP_SH = 24;
	localparam int DIV_RECIP_W = 24;
	localparam int DIV_RECIP = ((2 ** DIV_RECIP_SH) + SEG_LEN - 1) / SEG_LEN;
	localparam int DIV_CUR_W = REM_W + DIV_DIGIT_W;
	localparam int DIV_PROD_W = DIV_CUR_W + DIV_RECIP_W;
	localparam int SQ_CNT_W = $clog2(ROOT_W);
	localparam int CLR_N = (HIST_BINS > NSEG) ? HIST_BINS : NSEG;
	localparam int CLR_W = $clog2(CLR_N);
	localparam int BUF_W = 96;
	localparam int S_DATA_W = 112;
	localparam int M_DATA_W = 304;

	localparam logic [1:0] KIND_BEAD = 2'd0;
	localparam logic [1:0] KIND_HIST = 2'd1;
	localparam logic [1:0] KIND_SEG = 2'd2;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_SUM,
		S_MEAN_GO,
		S_MEAN_WT,
		S_DEV_RD,
		S_DEV_SQ,
		S_DEV_END,
		S_VDIV_GO,
		S_VDIV_WT,
		S_SQRT_GO,
		S_SQRT_WT,
		S_BIN,
		S_UPD,
		S_UPD_WR,
		S_OUT
	} state_t;

	typedef struct packed {
		logic rd;
		logic upd;
		logic [BIN_W-1:0] bin;
		logic [SEG_W-1:0] seg;
		logic [31:0] rad;
	} stats_req_t;

endpackage

// ===== hw/rtl/sgh_div.sv =====
module sgh_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [sgh_pkg::ACC_W-1:0] dividend,
	output logic done,
	output logic [sgh_pkg::ACC_W-1:0] quotient
);

	// Divides by SEG_LEN one byte per cycle; each byte digit comes from a
	// reciprocal multiplication that is exact for the remainder-prefixed byte.
	logic busy_q;
	logic done_q;
	logic [sgh_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [sgh_pkg::DIV_W-1:0] work_q;
	logic [sgh_pkg::REM_W-1:0] rem_q;
	logic [sgh_pkg::DIV_CUR_W-1:0] cur;
	logic [sgh_pkg::DIV_PROD_W-1:0] prod;
	logic [sgh_pkg::DIV_DIGIT_W-1:0] digit;
	logic [sgh_pkg::DIV_CUR_W-1:0] back;
	logic [sgh_pkg::REM_W-1:0] rem_n;

	assign cur = {rem_q, work_q[sgh_pkg::DIV_W-1 -: sgh_pkg::DIV_DIGIT_W]};
	assign prod = sgh_pkg::DIV_PROD_W'(cur) * sgh_pkg::DIV_PROD_W'(sgh_pkg::DIV_RECIP);
	assign digit = prod[sgh_pkg::DIV_RECIP_SH +: sgh_pkg::DIV_DIGIT_W];
	assign back = sgh_pkg::DIV_CUR_W'(digit) * sgh_pkg::DIV_CUR_W'(sgh_pkg::SEG_LEN);
	assign rem_n = sgh_pkg::REM_W'(cur - back);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == sgh_pkg::DIV_CNT_W'(sgh_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= sgh_pkg::DIV_W'(dividend);
			rem_q <= '0;
		end else if (busy_q) begin
			work_q <= {work_q[sgh_pkg::DIV_W-sgh_pkg::DIV_DIGIT_W-1:0], digit};
			rem_q <= rem_n;
		end
	end

	assign done = done_q;
	assign quotient = work_q[sgh_pkg::ACC_W-1:0];

endmodule

// ===== hw/rtl/sgh_sqrt.sv =====
module sgh_sqrt (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [sgh_pkg::SQ_W-1:0] radicand,
	output logic done,
	output logic [sgh_pkg::ROOT_W-1:0] root
);

	logic busy_q;
	logic done_q;
	logic [sgh_pkg::SQ_CNT_W-1:0] cnt_q;
	logic [sgh_pkg::SQ_W-1:0] rad_q;
	logic [sgh_pkg::ROOT_W-1:0] root_q;
	logic [sgh_pkg::ROOT_W+1:0] rem_q;
	logic [sgh_pkg::ROOT_W+3:0] cur;
	logic [sgh_pkg::ROOT_W+3:0] trial;
	logic [sgh_pkg::ROOT_W+3:0] diff;
	logic ge;

	assign cur = {rem_q, rad_q[sgh_pkg::SQ_W-1 -: 2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign ge = cur >= trial;
	assign diff = cur - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == sgh_pkg::SQ_CNT_W'(sgh_pkg::ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q <= radicand;
			root_q <= '0;
			rem_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[sgh_pkg::SQ_W-3:0], 2'b00};
			root_q <= {root_q[sgh_pkg::ROOT_W-2:0], ge};
			rem_q <= ge ? diff[sgh_pkg::ROOT_W+1:0] : cur[sgh_pkg::ROOT_W+1:0];
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ===== hw/rtl/sgh_stats.sv =====
module sgh_stats (
	input logic clk,
	input logic arst_n,
	input sgh_pkg::stats_req_t req,
	output logic busy,
	output logic [31:0] hist_rdata,
	output logic [63:0] sum_rdata,
	output logic [31:0] cnt_rdata
);

	logic [31:0] hist_mem [sgh_pkg::HIST_BINS];
	logic [95:0] seg_mem [sgh_pkg::NSEG];

	logic clr_q;
	logic [sgh_pkg::CLR_W-1:0] clr_cnt_q;
	logic upd_s1;
	logic [sgh_pkg::BIN_W-1:0] bin_s1;
	logic [sgh_pkg::SEG_W-1:0] seg_s1;
	logic [31:0] rad_s1;
	logic [31:0] hist_rd_q;
	logic [95:0] seg_rd_q;
	logic hist_clr;
	logic seg_clr;

	assign hist_clr = clr_q && (32'(clr_cnt_q) < 32'(sgh_pkg::HIST_BINS));
	assign seg_clr = clr_q && (32'(clr_cnt_q) < 32'(sgh_pkg::NSEG));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= 1'b1;
			clr_cnt_q <= '0;
			upd_s1 <= 1'b0;
		end else begin
			upd_s1 <= req.upd;
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == sgh_pkg::CLR_W'(sgh_pkg::CLR_N - 1)) begin
					clr_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		bin_s1 <= req.bin;
		seg_s1 <= req.seg;
		rad_s1 <= req.rad;
	end

	always_ff @(posedge clk) begin
		if (hist_clr) begin
			hist_mem[sgh_pkg::BIN_W'(clr_cnt_q)] <= '0;
		end else if (upd_s1) begin
			hist_mem[bin_s1] <= hist_rd_q + 32'd1;
		end
		if (req.rd || req.upd) begin
			hist_rd_q <= hist_mem[req.bin];
		end
	end

	always_ff @(posedge clk) begin
		if (seg_clr) begin
			seg_mem[sgh_pkg::SEG_W'(clr_cnt_q)] <= '0;
		end else if (upd_s1) begin
			seg_mem[seg_s1] <= {seg_rd_q[95:64] + 32'd1, seg_rd_q[63:0] + 64'(rad_s1)};
		end
		if (req.rd || req.upd) begin
			seg_rd_q <= seg_mem[req.seg];
		end
	end

	assign busy = clr_q;
	assign hist_rdata = hist_rd_q;
	assign sum_rdata = seg_rd_q[63:0];
	assign cnt_rdata = seg_rd_q[95:64];

endmodule

// ===== hw/rtl/segment_gyration_histogram.sv =====
// Radius-of-gyration histogram over fixed bead segments. Each frame of 400 beads is cut into
// 40 segments of 10 beads. The beat that completes a segment starts a sequence that runs
// before the next beat is taken: a walk over the segment buffer for the sums, four divisions
// by ten at one byte per cycle, a walk for the squared deviations, the two-bit-per-cycle
// square root, and then binning and the memory update. A read beat is answered from the
// output register, and the next beat is taken once its result has been loaded there. After
// reset the block takes no beat while it zeroes the histogram and segment memories;
// configuration writes are taken at any time.
`include "segment_gyration_histogram_assert.svh"

module segment_gyration_histogram (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	// pos_x, pos_y, pos_z, read_index, zero fill
	input logic [sgh_pkg::S_DATA_W-1:0] s_tdata,
	// kind
	input logic [1:0] s_tuser,
	output logic m_tvalid,
	input logic m_tready,
	// com_x, com_y, com_z, gyration_radius, bin_number, segment_number, bin_count,
	// radius_sum, frames_counted, total_segments
	output logic [sgh_pkg::M_DATA_W-1:0] m_tdata,
	// result_kind
	output logic [1:0] m_tuser,
	input logic cfg_wen,
	input logic [31:0] cfg_wdata
);

	sgh_pkg::state_t state_q, state_d;

	logic [31:0] bin_scale_q;
	logic [sgh_pkg::POS_W-1:0] pos_q;
	logic [sgh_pkg::SLOT_W-1:0] slot_q;
	logic [sgh_pkg::SEGC_W-1:0] seg_q;
	logic [sgh_pkg::SEG_W-1:0] done_seg_q;
	logic [31:0] total_q;
	logic [1:0] kind_q;
	logic rd_ok_q;
	logic [sgh_pkg::CNT_W-1:0] cnt_q;
	logic [1:0] axis_q;
	logic signed [sgh_pkg::SUM_W-1:0] sum_q [3];
	logic [31:0] com_q [3];
	logic [sgh_pkg::ACC_W-1:0] acc_q;
	logic [65:0] sq_s1;
	logic sq_vld_s1;
	logic [31:0] rad_q;
	logic [63:0] prod_s1;
	logic [sgh_pkg::BIN_W-1:0] bin_q;

	logic [sgh_pkg::BUF_W-1:0] buf_mem [sgh_pkg::SEG_LEN];
	logic [sgh_pkg::BUF_W-1:0] buf_rd_q;
	logic buf_re;
	logic [sgh_pkg::SLOT_W-1:0] buf_raddr;
	logic buf_we;

	logic m_tvalid_q;
	logic [sgh_pkg::M_DATA_W-1:0] m_tdata_q;
	logic [1:0] m_tuser_q;
	logic out_load;
	logic [sgh_pkg::M_DATA_W-1:0] out_data;

	logic accept;
	logic [1:0] in_kind;
	logic [9:0] in_idx;
	logic in_seg_ok;
	logic seg_last;
	logic pos_wrap;
	logic idx_ok;

	logic div_start;
	logic div_done;
	logic [sgh_pkg::ACC_W-1:0] div_dividend;
	logic [sgh_pkg::ACC_W-1:0] div_quot;
	logic sqrt_start;
	logic sqrt_done;
	logic [sgh_pkg::ROOT_W-1:0] sqrt_root;

	sgh_pkg::stats_req_t stats_req;
	logic stats_busy;
	logic [31:0] hist_rdata;
	logic [63:0] sum_rdata;
	logic [31:0] cnt_rdata;

	logic sum_neg;
	logic [sgh_pkg::SUM_W-1:0] sum_abs;
	logic [31:0] mean_mag;
	logic [31:0] cur_coord;
	logic [32:0] dev;
	logic [32:0] dev_abs;
	logic [31:0] rad_sat;
	logic [31:0] bin_hi;
	logic [sgh_pkg::BIN_W-1:0] bin_d;

	assign in_kind = s_tuser;
	assign in_idx = s_tdata[105:96];
	assign s_tready = (state_q == sgh_pkg::S_IDLE);
	assign accept = s_tvalid && s_tready;
	assign in_seg_ok = 32'(seg_q) < 32'(sgh_pkg::NSEG);
	assign seg_last = slot_q == sgh_pkg::SLOT_W'(sgh_pkg::SEG_LEN - 1);
	assign pos_wrap = (32'(pos_q) + 32'd1) >= 32'(sgh_pkg::BEADS_PER_FRAME);
	assign idx_ok = (in_kind == sgh_pkg::KIND_HIST) ? (32'(in_idx) < 32'(sgh_pkg::HIST_BINS))
		: (32'(in_idx) < 32'(sgh_pkg::NSEG));
	assign buf_we = accept && (in_kind == sgh_pkg::KIND_BEAD) && in_seg_ok;

	assign sum_neg = sum_q[axis_q][sgh_pkg::SUM_W-1];
	assign sum_abs = sum_neg ? sgh_pkg::SUM_W'(-sum_q[axis_q]) : sgh_pkg::SUM_W'(sum_q[axis_q]);
	assign mean_mag = div_quot[31:0];
	assign cur_coord = buf_rd_q[32*axis_q +: 32];
	assign dev = {cur_coord[31], cur_coord} - {com_q[axis_q][31], com_q[axis_q]};
	assign dev_abs = dev[32] ? -dev : dev;
	assign rad_sat = (sqrt_root[sgh_pkg::ROOT_W-1:32] != '0) ? 32'hFFFF_FFFF : sqrt_root[31:0];
	assign bin_hi = prod_s1[63:32];
	assign bin_d = (bin_hi > 32'(sgh_pkg::HIST_BINS - 1)) ? sgh_pkg::BIN_W'(sgh_pkg::HIST_BINS - 1)
		: sgh_pkg::BIN_W'(bin_hi);
	assign out_load = (state_q == sgh_pkg::S_OUT) && (!m_tvalid_q || m_tready);

	sgh_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(div_dividend),
		.done(div_done),
		.quotient(div_quot)
	);

	sgh_sqrt u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.start(sqrt_start),
		.radicand(sgh_pkg::SQ_W'(div_quot)),
		.done(sqrt_done),
		.root(sqrt_root)
	);

	sgh_stats u_stats (
		.clk(clk),
		.arst_n(arst_n),
		.req(stats_req),
		.busy(stats_busy),
		.hist_rdata(hist_rdata),
		.sum_rdata(sum_rdata),
		.cnt_rdata(cnt_rdata)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sgh_pkg::S_CLEAR: begin
				if (!stats_busy) state_d = sgh_pkg::S_IDLE;
			end
			sgh_pkg::S_IDLE: begin
				if (accept) begin
					if (in_kind == sgh_pkg::KIND_HIST || in_kind == sgh_pkg::KIND_SEG) begin
						state_d = sgh_pkg::S_OUT;
					end else if (buf_we && seg_last) begin
						state_d = sgh_pkg::S_SUM;
					end
				end
			end
			sgh_pkg::S_SUM: begin
				if (cnt_q == sgh_pkg::CNT_W'(sgh_pkg::SEG_LEN)) state_d = sgh_pkg::S_MEAN_GO;
			end
			sgh_pkg::S_MEAN_GO: state_d = sgh_pkg::S_MEAN_WT;
			sgh_pkg::S_MEAN_WT: begin
				if (div_done) begin
					state_d = (axis_q == 2'd2) ? sgh_pkg::S_DEV_RD : sgh_pkg::S_MEAN_GO;
				end
			end
			sgh_pkg::S_DEV_RD: state_d = sgh_pkg::S_DEV_SQ;
			sgh_pkg::S_DEV_SQ: begin
				if (axis_q == 2'd2) begin
					state_d = (cnt_q == sgh_pkg::CNT_W'(sgh_pkg::SEG_LEN - 1))
						? sgh_pkg::S_DEV_END : sgh_pkg::S_DEV_RD;
				end
			end
			sgh_pkg::S_DEV_END: state_d = sgh_pkg::S_VDIV_GO;
			sgh_pkg::S_VDIV_GO: state_d = sgh_pkg::S_VDIV_WT;
			sgh_pkg::S_VDIV_WT: begin
				if (div_done) state_d = sgh_pkg::S_SQRT_GO;
			end
			sgh_pkg::S_SQRT_GO: state_d = sgh_pkg::S_SQRT_WT;
			sgh_pkg::S_SQRT_WT: begin
				if (sqrt_done) state_d = sgh_pkg::S_BIN;
			end
			sgh_pkg::S_BIN: state_d = sgh_pkg::S_UPD;
			sgh_pkg::S_UPD: state_d = sgh_pkg::S_UPD_WR;
			sgh_pkg::S_UPD_WR: state_d = sgh_pkg::S_OUT;
			sgh_pkg::S_OUT: begin
				if (out_load) state_d = sgh_pkg::S_IDLE;
			end
			default: state_d = sgh_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		buf_re = 1'b0;
		buf_raddr = cnt_q[sgh_pkg::SLOT_W-1:0];
		div_start = 1'b0;
		div_dividend = sgh_pkg::ACC_W'(sum_abs);
		sqrt_start = 1'b0;
		stats_req = '0;
		unique case (state_q)
			sgh_pkg::S_IDLE: begin
				stats_req.rd = accept
					&& (in_kind == sgh_pkg::KIND_HIST || in_kind == sgh_pkg::KIND_SEG);
				stats_req.bin = sgh_pkg::BIN_W'(in_idx);
				stats_req.seg = (32'(in_idx) < 32'(sgh_pkg::NSEG)) ? sgh_pkg::SEG_W'(in_idx) : '0;
			end
			sgh_pkg::S_SUM: buf_re = cnt_q < sgh_pkg::CNT_W'(sgh_pkg::SEG_LEN);
			sgh_pkg::S_MEAN_GO: div_start = 1'b1;
			sgh_pkg::S_DEV_RD: buf_re = 1'b1;
			sgh_pkg::S_VDIV_GO: begin
				div_start = 1'b1;
				div_dividend = acc_q;
			end
			sgh_pkg::S_SQRT_GO: sqrt_start = 1'b1;
			sgh_pkg::S_UPD: begin
				stats_req.upd = 1'b1;
				stats_req.bin = bin_d;
				stats_req.seg = done_seg_q;
				stats_req.rad = rad_q;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		out_data = '0;
		unique case (kind_q)
			sgh_pkg::KIND_BEAD: begin
				out_data[31:0] = com_q[0];
				out_data[63:32] = com_q[1];
				out_data[95:64] = com_q[2];
				out_data[127:96] = rad_q;
				out_data[137:128] = 10'(bin_q);
				out_data[143:138] = 6'(done_seg_q);
				out_data[303:272] = total_q;
			end
			sgh_pkg::KIND_HIST: begin
				out_data[175:144] = rd_ok_q ? hist_rdata : 32'd0;
				out_data[303:272] = total_q;
			end
			sgh_pkg::KIND_SEG: begin
				out_data[239:176] = rd_ok_q ? sum_rdata : 64'd0;
				out_data[271:240] = rd_ok_q ? cnt_rdata : 32'd0;
				out_data[303:272] = total_q;
			end
			default: out_data = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sgh_pkg::S_CLEAR;
			bin_scale_q <= 32'd1310720;
			pos_q <= '0;
			slot_q <= '0;
			seg_q <= '0;
			total_q <= '0;
			kind_q <= sgh_pkg::KIND_BEAD;
			cnt_q <= '0;
			axis_q <= '0;
			sq_vld_s1 <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			sq_vld_s1 <= (state_q == sgh_pkg::S_DEV_SQ);
			if (cfg_wen) bin_scale_q <= cfg_wdata;
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (accept) kind_q <= in_kind;
			if (accept && in_kind == sgh_pkg::KIND_BEAD) begin
				if (pos_wrap) begin
					pos_q <= '0;
					slot_q <= '0;
					seg_q <= '0;
				end else begin
					pos_q <= pos_q + 1'b1;
					if (seg_last) begin
						slot_q <= '0;
						seg_q <= seg_q + 1'b1;
					end else begin
						slot_q <= slot_q + 1'b1;
					end
				end
			end
			unique case (state_q)
				sgh_pkg::S_IDLE: cnt_q <= '0;
				sgh_pkg::S_SUM: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == sgh_pkg::CNT_W'(sgh_pkg::SEG_LEN)) begin
						axis_q <= '0;
					end
				end
				sgh_pkg::S_MEAN_WT: begin
					if (div_done) begin
						if (axis_q == 2'd2) begin
							axis_q <= '0;
							cnt_q <= '0;
						end else begin
							axis_q <= axis_q + 1'b1;
						end
					end
				end
				sgh_pkg::S_DEV_SQ: begin
					if (axis_q == 2'd2) begin
						axis_q <= '0;
						cnt_q <= cnt_q + 1'b1;
					end else begin
						axis_q <= axis_q + 1'b1;
					end
				end
				sgh_pkg::S_UPD_WR: total_q <= total_q + 32'd1;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_ok_q <= idx_ok;
			done_seg_q <= sgh_pkg::SEG_W'(seg_q);
		end
		if (state_q == sgh_pkg::S_IDLE) begin
			sum_q[0] <= '0;
			sum_q[1] <= '0;
			sum_q[2] <= '0;
		end else if (state_q == sgh_pkg::S_SUM && cnt_q != '0) begin
			sum_q[0] <= sum_q[0] + {{(sgh_pkg::SUM_W-32){buf_rd_q[31]}}, buf_rd_q[31:0]};
			sum_q[1] <= sum_q[1] + {{(sgh_pkg::SUM_W-32){buf_rd_q[63]}}, buf_rd_q[63:32]};
			sum_q[2] <= sum_q[2] + {{(sgh_pkg::SUM_W-32){buf_rd_q[95]}}, buf_rd_q[95:64]};
		end
		if (state_q == sgh_pkg::S_MEAN_WT && div_done) begin
			com_q[axis_q] <= sum_neg ? -mean_mag : mean_mag;
		end
		if (state_q == sgh_pkg::S_MEAN_WT && div_done && axis_q == 2'd2) begin
			acc_q <= '0;
		end else if (sq_vld_s1) begin
			acc_q <= acc_q + sgh_pkg::ACC_W'(sq_s1);
		end
		if (state_q == sgh_pkg::S_DEV_SQ) sq_s1 <= dev_abs * dev_abs;
		if (state_q == sgh_pkg::S_SQRT_WT && sqrt_done) rad_q <= rad_sat;
		if (state_q == sgh_pkg::S_BIN) prod_s1 <= rad_q * bin_scale_q;
		if (state_q == sgh_pkg::S_UPD) bin_q <= bin_d;
		if (out_load) begin
			m_tdata_q <= out_data;
			m_tuser_q <= kind_q;
		end
	end

	always_ff @(posedge clk) begin
		if (buf_we) begin
			buf_mem[slot_q] <= s_tdata[95:0];
		end
		if (buf_re) begin
			buf_rd_q <= buf_mem[buf_raddr];
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;

	`SGH_ASSERT_NOW(a_no_beat_in_clear, stats_busy, !s_tready, "beat taken during clear pass")
	`SGH_ASSERT_NOW(a_div_done_waited, div_done, (state_q == sgh_pkg::S_MEAN_WT) || (state_q == sgh_pkg::S_VDIV_WT), "divider finished outside a wait state")
	`SGH_ASSERT_NEXT(a_out_loaded, out_load, m_tvalid, "result not presented after load")
	`SGH_ASSERT_NOW(a_upd_in_range, stats_req.upd, 32'(stats_req.seg) < 32'(sgh_pkg::NSEG), "segment update out of range")

endmodule

// ===== tb/segment_gyration_histogram_test.sv =====
`timescale 1ns / 1ps

module segment_gyration_histogram_test;

	localparam logic [1:0] KIND_NONE = 2'd3;
	localparam int SETTLE_CYCLES = 500;
	localparam int LONG_HOLD = 3000;

	typedef struct {
		logic [1:0] kind;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic [9:0] idx;
	} bead_beat_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [31:0] com_x;
		logic [31:0] com_y;
		logic [31:0] com_z;
		logic [31:0] radius;
		logic [9:0] bin;
		logic [5:0] seg;
		logic [31:0] bin_count;
		logic [63:0] radius_sum;
		logic [31:0] frames;
		logic [31:0] total;
	} seg_stat_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [sgh_pkg::S_DATA_W-1:0] s_tdata;
	logic [1:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [sgh_pkg::M_DATA_W-1:0] m_tdata;
	logic [1:0] m_tuser;
	logic cfg_wen;
	logic [31:0] cfg_wdata;

	bead_beat_t pending_beats[$];
	seg_stat_t expected_stats[$];
	int mismatches;
	int gap_left;
	bit no_gaps;
	int hold_asked;
	int hold_served;
	int hold_left;

	logic [31:0] scale_q;
	int bead_pos;
	logic signed [31:0] buf_x[sgh_pkg::SEG_LEN];
	logic signed [31:0] buf_y[sgh_pkg::SEG_LEN];
	logic signed [31:0] buf_z[sgh_pkg::SEG_LEN];
	logic [31:0] hist_q[sgh_pkg::HIST_BINS];
	logic [63:0] seg_sum_q[sgh_pkg::NSEG];
	logic [31:0] seg_cnt_q[sgh_pkg::NSEG];
	logic [31:0] total_q;

	segment_gyration_histogram dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_wen(cfg_wen),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 70)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(20, 60);
	endfunction

	function automatic longint signed segment_mean(logic signed [31:0] v[sgh_pkg::SEG_LEN]);
		longint signed s;
		s = 0;
		for (int i = 0; i < sgh_pkg::SEG_LEN; i++)
			s += v[i];
		return s / sgh_pkg::SEG_LEN;
	endfunction

	function automatic logic [127:0] square_dev(logic signed [31:0] v, longint signed c);
		longint signed d;
		logic [127:0] m;
		d = v - c;
		m = (d < 0) ? -d : d;
		return m * m;
	endfunction

	function automatic logic [31:0] floor_root(logic [127:0] v);
		logic [63:0] r;
		logic [127:0] t;
		r = 0;
		for (int b = 35; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= v)
				r = t[63:0];
		end
		return (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
	endfunction

	task automatic predict_beat(bead_beat_t b);
		seg_stat_t e;
		int seg;
		int slot;
		longint signed cx, cy, cz;
		logic [127:0] acc;
		logic [63:0] prod;
		logic [63:0] bin;
		e = '0;
		e.kind = b.kind;
		if (b.kind == sgh_pkg::KIND_HIST) begin
			e.bin_count = hist_q[b.idx];
			e.total = total_q;
			expected_stats.push_back(e);
		end else if (b.kind == sgh_pkg::KIND_SEG) begin
			if (b.idx < sgh_pkg::NSEG) begin
				e.radius_sum = seg_sum_q[b.idx];
				e.frames = seg_cnt_q[b.idx];
			end
			e.total = total_q;
			expected_stats.push_back(e);
		end else if (b.kind == sgh_pkg::KIND_BEAD) begin
			seg = bead_pos / sgh_pkg::SEG_LEN;
			slot = bead_pos % sgh_pkg::SEG_LEN;
			bead_pos = (bead_pos + 1 >= sgh_pkg::BEADS_PER_FRAME) ? 0 : bead_pos + 1;
			if (seg < sgh_pkg::NSEG) begin
				buf_x[slot] = b.x;
				buf_y[slot] = b.y;
				buf_z[slot] = b.z;
				if (slot == sgh_pkg::SEG_LEN - 1) begin
					cx = segment_mean(buf_x);
					cy = segment_mean(buf_y);
					cz = segment_mean(buf_z);
					acc = 0;
					for (int i = 0; i < sgh_pkg::SEG_LEN; i++)
						acc += square_dev(buf_x[i], cx) + square_dev(buf_y[i], cy)
							+ square_dev(buf_z[i], cz);
					e.radius = floor_root(acc / sgh_pkg::SEG_LEN);
					prod = {32'd0, e.radius} * {32'd0, scale_q};
					bin = prod >> 32;
					if (bin > sgh_pkg::HIST_BINS - 1)
						bin = sgh_pkg::HIST_BINS - 1;
					hist_q[bin] += 1;
					seg_sum_q[seg] += e.radius;
					seg_cnt_q[seg] += 1;
					total_q += 1;
					e.com_x = cx[31:0];
					e.com_y = cy[31:0];
					e.com_z = cz[31:0];
					e.bin = bin[9:0];
					e.seg = seg[5:0];
					e.total = total_q;
					expected_stats.push_back(e);
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		bead_beat_t b;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			gap_left <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				b.kind = s_tuser;
				b.x = s_tdata[31:0];
				b.y = s_tdata[63:32];
				b.z = s_tdata[95:64];
				b.idx = s_tdata[105:96];
				predict_beat(b);
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					s_tvalid <= 1'b0;
				end else if (pending_beats.size() > 0) begin
					b = pending_beats.pop_front();
					s_tdata <= {6'd0, b.idx, b.z, b.y, b.x};
					s_tuser <= b.kind;
					s_tvalid <= 1'b1;
					gap_left <= pick_gap();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		seg_stat_t a, e;
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_left <= 0;
			hold_served <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				a.kind = m_tuser;
				a.com_x = m_tdata[31:0];
				a.com_y = m_tdata[63:32];
				a.com_z = m_tdata[95:64];
				a.radius = m_tdata[127:96];
				a.bin = m_tdata[137:128];
				a.seg = m_tdata[143:138];
				a.bin_count = m_tdata[175:144];
				a.radius_sum = m_tdata[239:176];
				a.frames = m_tdata[271:240];
				a.total = m_tdata[303:272];
				if (expected_stats.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Unexpected result beat: kind %0d total %0d", a.kind, a.total);
				end else begin
					e = expected_stats.pop_front();
					if (a != e) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("Mismatch expected: %p", e);
							$display("         actual:   %p", a);
						end
					end
				end
			end
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				m_tready <= 1'b0;
			end else if (hold_served < hold_asked) begin
				hold_served <= hold_served + 1;
				hold_left <= LONG_HOLD;
				m_tready <= 1'b0;
			end else begin
				hold_left <= pick_gap();
				m_tready <= 1'b1;
			end
		end
	end

	task automatic wait_quiet();
		while (pending_beats.size() > 0 || s_tvalid || expected_stats.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_scale(logic [31:0] v);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen <= 1'b0;
		scale_q = v;
	endtask

	task automatic add_beat(logic [1:0] k, logic [31:0] x, logic [31:0] y, logic [31:0] z,
			logic [9:0] i);
		bead_beat_t b;
		b.kind = k;
		b.x = x;
		b.y = y;
		b.z = z;
		b.idx = i;
		pending_beats.push_back(b);
	endtask

	task automatic add_random_segment();
		logic [31:0] cx, cy, cz;
		logic [31:0] mask;
		int sel;
		cx = $urandom;
		cy = $urandom;
		cz = $urandom;
		sel = $urandom_range(0, 9);
		mask = (sel == 0) ? 32'hFFFF_FFFF : ((32'd1 << $urandom_range(4, 24)) - 32'd1);
		for (int i = 0; i < sgh_pkg::SEG_LEN; i++) begin
			if (sel == 1)
				add_beat(sgh_pkg::KIND_BEAD,
					$urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF,
					$urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF,
					$urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF, 10'($urandom));
			else
				add_beat(sgh_pkg::KIND_BEAD, cx + ($urandom & mask), cy + ($urandom & mask),
					cz + ($urandom & mask), 10'($urandom));
			if ($urandom_range(0, 9) == 0)
				add_beat(2'($urandom_range(1, 3)), $urandom, $urandom, $urandom,
					$urandom_range(0, 1) ? 10'($urandom_range(0, 63)) : 10'($urandom));
		end
	endtask

	task automatic add_random_phase(int n);
		int start;
		start = pending_beats.size();
		while (pending_beats.size() - start < n) begin
			if ($urandom_range(0, 9) < 8)
				add_random_segment();
			else
				add_beat(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
					$urandom_range(0, 1) ? 10'($urandom_range(0, 63)) : 10'($urandom));
		end
	endtask

	initial begin
		logic [31:0] scales[5];
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_wdata = '0;
		mismatches = 0;
		no_gaps = 1'b0;
		hold_asked = 0;
		scale_q = 32'd1310720;
		bead_pos = 0;
		total_q = 0;
		for (int i = 0; i < sgh_pkg::HIST_BINS; i++)
			hist_q[i] = 0;
		for (int i = 0; i < sgh_pkg::NSEG; i++) begin
			seg_sum_q[i] = 0;
			seg_cnt_q[i] = 0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		add_beat(sgh_pkg::KIND_HIST, 0, 0, 0, 10'd0);
		add_beat(sgh_pkg::KIND_HIST, 0, 0, 0, 10'd1023);
		add_beat(sgh_pkg::KIND_SEG, 0, 0, 0, 10'd39);
		add_beat(sgh_pkg::KIND_SEG, 0, 0, 0, 10'd40);
		add_beat(sgh_pkg::KIND_SEG, 0, 0, 0, 10'd1023);
		add_beat(KIND_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'd1023);
		for (int i = 0; i < sgh_pkg::SEG_LEN; i++)
			add_beat(sgh_pkg::KIND_BEAD, 32'h0, 32'h0, 32'h0, 10'd0);
		for (int i = 0; i < sgh_pkg::SEG_LEN; i++)
			add_beat(sgh_pkg::KIND_BEAD, i[0] ? 32'h7FFF_FFFF : 32'h8000_0000,
				i[0] ? 32'h8000_0000 : 32'h7FFF_FFFF,
				i[0] ? 32'h7FFF_FFFF : 32'h8000_0000, 10'h3FF);
		add_beat(sgh_pkg::KIND_HIST, 0, 0, 0, 10'd1023);
		add_beat(sgh_pkg::KIND_SEG, 0, 0, 0, 10'd1);
		wait_quiet();

		scales = '{32'd1310720, 32'd1, 32'hFFFF_FFFF, 32'd0, $urandom};
		for (int p = 0; p < 5; p++) begin
			write_scale(scales[p]);
			no_gaps = (p == 1);
			if (p == 2)
				hold_asked = 1;
			add_random_phase(340);
			wait_quiet();
		end

		if (mismatches == 0 && expected_stats.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		#50ms;
		$display("Verification failed");
		$finish;
	end

endmodule
